@@ rtl/assert_macros.svh @@
// assertion helpers included by axi_to_apb_bridge_unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/abb_pkg.sv @@
// ----------------------------------------------------------------------------
// abb_pkg
// types and constants of the axi to apb bridge
// ----------------------------------------------------------------------------
`default_nettype none

package abb_pkg;

  localparam int NUM_SLAVES_DEF = 4;
  localparam int NUM_WINDOWS    = 4;
  localparam int WIN_IDX_W      = 2;
  localparam int SLV_IDX_W      = 3;

  localparam logic [31:0] DEFAULT_RDATA = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SETUP  = 2'd1,
    PH_ACCESS = 2'd2,
    PH_OUT    = 2'd3
  } phase_t;

  typedef logic [NUM_WINDOWS-1:0][63:0] window_array_t;

  typedef struct packed {
    logic        req_valid;
    logic [31:0] req_addr;
    logic [3:0]  req_size;
    logic        req_write;
    logic [63:0] req_wdata;
    logic [7:0]  req_wstrb;
    logic        req_last;
    logic        slv_ready;
    logic [31:0] slv_rdata;
    logic        slv_err;
  } tick_t;

  typedef struct packed {
    logic        req_accept;
    logic        resp_valid;
    logic [63:0] resp_rdata;
    logic        resp_err;
    logic [2:0]  target_slave;
    logic        apb_select;
    logic        apb_enable;
    logic [31:0] apb_addr;
    logic        apb_write;
    logic [31:0] apb_wdata;
    logic [3:0]  apb_strobe;
    logic [2:0]  apb_prot;
  } view_t;

endpackage

`default_nettype wire

@@ rtl/abb_if.sv @@
// ----------------------------------------------------------------------------
// abb channel interfaces
// valid/ready channels for ticks in, views out and window writes
// ----------------------------------------------------------------------------
`default_nettype none

interface abb_tick_if;
  logic          valid;
  logic          ready;
  abb_pkg::tick_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface abb_view_if;
  logic          valid;
  logic          ready;
  abb_pkg::view_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface abb_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [abb_pkg::WIN_IDX_W-1:0]   index;
  logic [63:0]                     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/abb_decode.sv @@
// ----------------------------------------------------------------------------
// abb_decode
// address window decode, highest matching slave wins
// ----------------------------------------------------------------------------
`default_nettype none

module abb_decode #(
  parameter int NUM_SLAVES = abb_pkg::NUM_SLAVES_DEF
) (
  input  wire logic [31:0]                     addr,
  input  wire abb_pkg::window_array_t          windows,
  output logic [abb_pkg::SLV_IDX_W-1:0]        sel
);
  import abb_pkg::*;

  always_comb begin
    sel = SLV_IDX_W'(NUM_SLAVES);
    for (int i = 0; i < NUM_SLAVES; i++) begin
      if (addr >= windows[i][31:0] && addr < windows[i][63:32]) begin
        sel = SLV_IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/abb_core.sv @@
// ----------------------------------------------------------------------------
// abb_core
// bridge phase machine and transfer registers, one step per accepted tick
// ----------------------------------------------------------------------------
`default_nettype none

module abb_core #(
  parameter int NUM_SLAVES = abb_pkg::NUM_SLAVES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   advance,
  input  wire abb_pkg::tick_t         tick,
  input  wire abb_pkg::window_array_t windows,
  output abb_pkg::view_t              view
);
  import abb_pkg::*;

  phase_t               phase, phase_next;
  logic [SLV_IDX_W-1:0] selected, selected_next, dec_sel;
  logic                 resp_flag, resp_flag_next;
  logic [31:0]          xfer_addr, xfer_addr_next;
  logic [31:0]          xfer_wdata, xfer_wdata_next;
  logic [63:0]          read_buffer, read_buffer_next;
  logic                 xfer_write, xfer_write_next;
  logic [3:0]           xfer_strobe, xfer_strobe_next;
  logic                 select_flag, select_flag_next;
  logic                 enable_flag, enable_flag_next;
  logic                 error_flag, error_flag_next;
  logic [3:0]           bytes_left, bytes_left_next;

  logic        mapped;
  logic        rdy;
  logic [31:0] rd;
  logic        er;

  abb_decode #(.NUM_SLAVES(NUM_SLAVES)) u_decode (
    .addr    (tick.req_addr),
    .windows (windows),
    .sel     (dec_sel)
  );

  assign mapped = selected < SLV_IDX_W'(NUM_SLAVES);
  assign rdy    = mapped ? tick.slv_ready : 1'b1;
  assign rd     = mapped ? tick.slv_rdata : DEFAULT_RDATA;
  assign er     = mapped ? tick.slv_err   : 1'b1;

  // next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_IDLE: begin
        if (tick.req_valid) begin
          phase_next = tick.req_last ? PH_SETUP : PH_OUT;
        end
      end
      PH_SETUP:  phase_next = PH_ACCESS;
      PH_ACCESS: begin
        if (rdy) begin
          phase_next = (bytes_left > 4'd4) ? PH_SETUP : PH_OUT;
        end
      end
      default:   phase_next = PH_IDLE;
    endcase
  end

  // next transfer registers
  always_comb begin
    selected_next    = selected;
    resp_flag_next   = 1'b0;
    xfer_addr_next   = xfer_addr;
    xfer_wdata_next  = xfer_wdata;
    read_buffer_next = read_buffer;
    xfer_write_next  = xfer_write;
    xfer_strobe_next = xfer_strobe;
    select_flag_next = select_flag;
    enable_flag_next = enable_flag;
    error_flag_next  = error_flag;
    bytes_left_next  = bytes_left;
    case (phase)
      PH_IDLE: begin
        error_flag_next  = 1'b0;
        enable_flag_next = 1'b0;
        select_flag_next = 1'b0;
        selected_next    = dec_sel;
        if (tick.req_valid) begin
          xfer_write_next  = tick.req_write;
          select_flag_next = 1'b1;
          xfer_addr_next   = {tick.req_addr[31:2], 2'b00};
          if (tick.req_addr[2]) begin
            xfer_wdata_next  = tick.req_wdata[63:32];
            xfer_strobe_next = tick.req_wstrb[7:4];
          end else begin
            xfer_wdata_next  = tick.req_wdata[31:0];
            xfer_strobe_next = tick.req_wstrb[3:0];
          end
          bytes_left_next = tick.req_size;
          if (!tick.req_last) begin
            select_flag_next = 1'b0;
            error_flag_next  = 1'b1;
            read_buffer_next = '1;
            resp_flag_next   = 1'b1;
          end
        end
      end
      PH_SETUP: begin
        enable_flag_next = 1'b1;
      end
      PH_ACCESS: begin
        error_flag_next = er;
        if (rdy) begin
          enable_flag_next = 1'b0;
          if (xfer_addr[2]) begin
            read_buffer_next = {rd, read_buffer[31:0]};
          end else begin
            read_buffer_next = {read_buffer[63:32], rd};
          end
          if (bytes_left > 4'd4) begin
            bytes_left_next  = bytes_left - 4'd4;
            xfer_addr_next   = xfer_addr + 32'd4;
            xfer_wdata_next  = tick.req_wdata[63:32];
            xfer_strobe_next = tick.req_wstrb[7:4];
          end else begin
            resp_flag_next   = 1'b1;
            select_flag_next = 1'b0;
            xfer_write_next  = 1'b0;
          end
        end
      end
      default: begin
        error_flag_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      selected    <= SLV_IDX_W'(NUM_SLAVES);
      resp_flag   <= 1'b0;
      xfer_addr   <= '0;
      xfer_wdata  <= '0;
      read_buffer <= '0;
      xfer_write  <= 1'b0;
      xfer_strobe <= '0;
      select_flag <= 1'b0;
      enable_flag <= 1'b0;
      error_flag  <= 1'b0;
      bytes_left  <= '0;
    end else if (advance) begin
      phase       <= phase_next;
      selected    <= selected_next;
      resp_flag   <= resp_flag_next;
      xfer_addr   <= xfer_addr_next;
      xfer_wdata  <= xfer_wdata_next;
      read_buffer <= read_buffer_next;
      xfer_write  <= xfer_write_next;
      xfer_strobe <= xfer_strobe_next;
      select_flag <= select_flag_next;
      enable_flag <= enable_flag_next;
      error_flag  <= error_flag_next;
      bytes_left  <= bytes_left_next;
    end
  end

  // bus view of the state before this tick
  always_comb begin
    view.req_accept   = (phase == PH_IDLE);
    view.resp_valid   = resp_flag;
    view.resp_rdata   = read_buffer;
    view.resp_err     = error_flag;
    view.target_slave = selected;
    view.apb_select   = mapped & select_flag;
    view.apb_enable   = mapped & enable_flag;
    view.apb_addr     = xfer_addr;
    view.apb_write    = xfer_write;
    view.apb_wdata    = xfer_wdata;
    view.apb_strobe   = xfer_strobe;
    view.apb_prot     = 3'b000;
  end

endmodule

`default_nettype wire

@@ rtl/axi_to_apb_bridge_unit.sv @@
// ----------------------------------------------------------------------------
// axi_to_apb_bridge_unit
// clock-tick model of an axi to apb bridge with four decoded slave windows
// ----------------------------------------------------------------------------
//   channel   dir   word                      handshake
//   in_ch     in    one bus tick (tick_t)     valid / ready
//   out_ch    out   bus view (view_t)         valid / ready
//   cfg       in    window index + 64b data   valid / ready, ready tied high
//
// one tick word is accepted per cycle while in_ch.ready is high; its view word appears in
// the output register in the next cycle and shows the state before the single phase machine
// step per tick; in_ch.ready drops only while a view word waits in out_ch
// rst is synchronous: idle phase, unmapped target, windows and flags cleared
// ----------------------------------------------------------------------------
`default_nettype none

module axi_to_apb_bridge_unit #(
  parameter int NUM_SLAVES = abb_pkg::NUM_SLAVES_DEF
) (
  input wire logic clk,
  input wire logic rst,
  abb_tick_if.sink   in_ch,
  abb_view_if.source out_ch,
  abb_cfg_if.sink    cfg
);
  import abb_pkg::*;
  `include "assert_macros.svh"

  window_array_t windows;
  logic          advance;
  view_t         view;
  logic          out_valid;
  view_t         out_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      windows <= '0;
    end else if (cfg.valid && cfg.ready) begin
      windows[cfg.index] <= cfg.data;
    end
  end

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign advance     = in_ch.valid && in_ch.ready;

  abb_core #(.NUM_SLAVES(NUM_SLAVES)) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .tick    (in_ch.data),
    .windows (windows),
    .view    (view)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= view;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  `ASSERT_SAME(a_stall_blocks_input, clk, rst, out_ch.valid && !out_ch.ready, !in_ch.ready)
  `ASSERT_NEXT(a_tick_gives_word, clk, rst, in_ch.valid && in_ch.ready, out_ch.valid)
  `ASSERT_SAME(a_enable_needs_select, clk, rst, out_ch.valid && out_ch.data.apb_enable, out_ch.data.apb_select)
  `ASSERT_SAME(a_resp_not_idle, clk, rst, out_ch.valid && out_ch.data.resp_valid, !out_ch.data.req_accept)

endmodule

`default_nettype wire
